// ===== design/bfs_pkg.sv =====
// Shared types, constants and helpers for the bilinear fit scaler.
// No dependencies.
package bfs_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COL_BITS  = 8;
  localparam int ROW_BITS  = 8;
  localparam int ADDR_BITS = COL_BITS + ROW_BITS;
  localparam int PIX_W     = 32;
  localparam int SRC_DIM_W = 9;
  localparam int DST_DIM_W = 13;
  localparam int COORD_W   = 12;
  localparam int INV_W     = SRC_DIM_W + FRAC_BITS;
  localparam int WT_W      = FRAC_BITS + 1;
  localparam int DIV_W     = 32;
  localparam int DVS_W     = 16;

  localparam logic [SRC_DIM_W-1:0] SRC_W_MAX = SRC_DIM_W'(1 << COL_BITS);
  localparam logic [SRC_DIM_W-1:0] SRC_H_MAX = SRC_DIM_W'(1 << ROW_BITS);
  localparam logic [DST_DIM_W-1:0] DST_MAX   = DST_DIM_W'(1 << COORD_W);
  localparam logic [INV_W-1:0]     ONE_Q     = INV_W'(1) << FRAC_BITS;

  // configuration register indexes
  localparam logic [2:0] CFG_SRC_W  = 3'd0;
  localparam logic [2:0] CFG_SRC_H  = 3'd1;
  localparam logic [2:0] CFG_DST_W  = 3'd2;
  localparam logic [2:0] CFG_DST_H  = 3'd3;
  localparam logic [2:0] CFG_BG     = 3'd4;
  localparam logic [2:0] CFG_FMT    = 3'd5;
  localparam logic [2:0] CFG_BOTTOM = 3'd6;

  localparam logic [1:0] FMT_PREMUL   = 2'd0;
  localparam logic [1:0] FMT_STRAIGHT = 2'd1;
  localparam logic [1:0] FMT_OPAQUE   = 2'd2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  typedef struct packed {
    logic               operation;
    logic               start_of_frame;
    logic [7:0]         in_blue;
    logic [7:0]         in_green;
    logic [7:0]         in_red;
    logic [7:0]         in_alpha;
    logic [COORD_W-1:0] dest_x;
    logic [COORD_W-1:0] dest_y;
  } in_req_t;

  typedef struct packed {
    logic [7:0] out_blue;
    logic [7:0] out_green;
    logic [7:0] out_red;
    logic [7:0] out_alpha;
    logic       inside_image;
  } out_rsp_t;

  // clamped sizes and derived geometry
  typedef struct packed {
    logic [SRC_DIM_W-1:0] src_w;
    logic [SRC_DIM_W-1:0] src_h;
    logic [DST_DIM_W-1:0] dst_w;
    logic [DST_DIM_W-1:0] dst_h;
    logic [INV_W-1:0]     inv_scale;
    logic [DST_DIM_W-1:0] scaled_w;
    logic [DST_DIM_W-1:0] scaled_h;
    logic [COORD_W-1:0]   off_x;
    logic [COORD_W-1:0]   off_y;
    logic [PIX_W-1:0]     bg_pm;
    logic [1:0]           fmt;
    logic                 bottom_up;
  } setup_t;

  // floor(x / 255), exact for x below 65280
  function automatic logic [7:0] div255(input logic [16:0] x);
    logic [17:0] t;
    t = {1'b0, x} + 18'd1 + {9'b0, x[16:8]};
    return t[15:8];
  endfunction

  // (c * a + 127) / 255
  function automatic logic [7:0] premul(input logic [7:0] c, input logic [7:0] a);
    logic [16:0] p;
    p = 17'(c) * 17'(a) + 17'd127;
    return div255(p);
  endfunction

endpackage

// ===== design/bfs_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on bfs_pkg.
module bfs_div import bfs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic [DVS_W-1:0]       rem_r;
  logic [DIV_W-1:0]       quo_r;
  logic [DVS_W-1:0]       dvs_r;
  logic [$clog2(DIV_W):0] cnt_r;
  logic                   busy_r, done_r;
  logic [DVS_W:0]         shf;
  logic                   fits;

  assign shf  = {rem_r, quo_r[DIV_W-1]};
  assign fits = shf >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= ($clog2(DIV_W)+1)'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? DVS_W'(shf - {1'b0, dvs_r}) : shf[DVS_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], fits};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ===== design/bfs_ram.sv =====
// Single-port synchronous RAM, registered read.
// No dependencies.
module bfs_ram #(
  parameter int AW = 16,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

// ===== design/bfs_setup.sv =====
// Configuration registers and the sequencer that derives fit geometry.
// Depends on bfs_pkg and bfs_div.
module bfs_setup import bfs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output setup_t      su
);

  localparam logic [3:0] SU_IDLE = 4'd0;
  localparam logic [3:0] SU_SEL  = 4'd1;
  localparam logic [3:0] SU_W0   = 4'd2;
  localparam logic [3:0] SU_W1   = 4'd3;
  localparam logic [3:0] SU_H0   = 4'd4;
  localparam logic [3:0] SU_H1   = 4'd5;
  localparam logic [3:0] SU_I0   = 4'd6;
  localparam logic [3:0] SU_I1   = 4'd7;
  localparam logic [3:0] SU_FIN  = 4'd8;

  logic [3:0]           st_r;
  logic [SRC_DIM_W-1:0] sw_raw_r, sh_raw_r, sw_c, sh_c;
  logic [DST_DIM_W-1:0] dw_raw_r, dh_raw_r, dw_c, dh_c;
  logic [31:0]          bg_raw_r;
  logic [1:0]           fmt_r;
  logic                 bu_r;
  logic [DST_DIM_W-1:0] num_r;
  logic [SRC_DIM_W-1:0] den_r;
  logic [INV_W-1:0]     inv_r;
  logic [DST_DIM_W-1:0] w_r, h_r;
  logic [COORD_W-1:0]   offx_r, offy_r;
  logic [PIX_W-1:0]     bgpm_r;
  logic                 div_start, div_busy, div_done;
  logic [DIV_W-1:0]     div_a, div_q;
  logic [DVS_W-1:0]     div_b;
  logic                 shrink, by_w;
  logic [DST_DIM_W-1:0] q13, dx_diff, dy_diff;
  logic [7:0]           bg_a;

  always_comb begin
    sw_c = (sw_raw_r == '0) ? SRC_DIM_W'(1) : (sw_raw_r > SRC_W_MAX) ? SRC_W_MAX : sw_raw_r;
    sh_c = (sh_raw_r == '0) ? SRC_DIM_W'(1) : (sh_raw_r > SRC_H_MAX) ? SRC_H_MAX : sh_raw_r;
    dw_c = (dw_raw_r == '0) ? DST_DIM_W'(1) : (dw_raw_r > DST_MAX) ? DST_MAX : dw_raw_r;
    dh_c = (dh_raw_r == '0) ? DST_DIM_W'(1) : (dh_raw_r > DST_MAX) ? DST_MAX : dh_raw_r;
    shrink = (dw_c < DST_DIM_W'(sw_c)) || (dh_c < DST_DIM_W'(sh_c));
    by_w   = (22'(dw_c) * 22'(sh_c)) <= (22'(dh_c) * 22'(sw_c));
  end

  // dividend/divisor per phase: scaled width, scaled height, inverse scale
  always_comb begin
    div_start = (st_r == SU_W0) || (st_r == SU_H0) || (st_r == SU_I0);
    unique case (st_r)
      SU_W0: begin
        div_a = ((DIV_W'(sw_c) * DIV_W'(num_r)) << 1) + DIV_W'(den_r);
        div_b = DVS_W'({den_r, 1'b0});
      end
      SU_H0: begin
        div_a = ((DIV_W'(sh_c) * DIV_W'(num_r)) << 1) + DIV_W'(den_r);
        div_b = DVS_W'({den_r, 1'b0});
      end
      default: begin
        div_a = DIV_W'({den_r, {FRAC_BITS{1'b0}}}) + DIV_W'(num_r >> 1);
        div_b = DVS_W'(num_r);
      end
    endcase
  end

  bfs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_a),
    .divisor  (div_b),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign q13     = (div_q == '0) ? DST_DIM_W'(1) : div_q[DST_DIM_W-1:0];
  assign dx_diff = dw_c - w_r;
  assign dy_diff = dh_c - h_r;
  assign bg_a    = bg_raw_r[31:24];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= SU_IDLE;
      sw_raw_r <= SRC_DIM_W'(1);
      sh_raw_r <= SRC_DIM_W'(1);
      dw_raw_r <= DST_DIM_W'(1);
      dh_raw_r <= DST_DIM_W'(1);
      bg_raw_r <= '0;
      fmt_r    <= FMT_PREMUL;
      bu_r     <= 1'b0;
      num_r    <= DST_DIM_W'(1);
      den_r    <= SRC_DIM_W'(1);
      inv_r    <= ONE_Q;
      w_r      <= DST_DIM_W'(1);
      h_r      <= DST_DIM_W'(1);
      offx_r   <= '0;
      offy_r   <= '0;
      bgpm_r   <= '0;
    end else begin
      unique case (st_r)
        SU_IDLE: begin
          if (cfg_valid) begin
            if (cfg_index <= CFG_BOTTOM) st_r <= SU_SEL;
            unique case (cfg_index)
              CFG_SRC_W:  sw_raw_r <= cfg_data[SRC_DIM_W-1:0];
              CFG_SRC_H:  sh_raw_r <= cfg_data[SRC_DIM_W-1:0];
              CFG_DST_W:  dw_raw_r <= cfg_data[DST_DIM_W-1:0];
              CFG_DST_H:  dh_raw_r <= cfg_data[DST_DIM_W-1:0];
              CFG_BG:     bg_raw_r <= cfg_data;
              CFG_FMT:    fmt_r    <= cfg_data[1:0];
              CFG_BOTTOM: bu_r     <= cfg_data[0];
              default: ;
            endcase
          end
        end
        SU_SEL: begin
          if (!shrink) begin
            num_r <= DST_DIM_W'(1);
            den_r <= SRC_DIM_W'(1);
          end else if (by_w) begin
            num_r <= dw_c;
            den_r <= sw_c;
          end else begin
            num_r <= dh_c;
            den_r <= sh_c;
          end
          st_r <= SU_W0;
        end
        SU_W0: st_r <= SU_W1;
        SU_W1: if (div_done) begin
          w_r  <= q13;
          st_r <= SU_H0;
        end
        SU_H0: st_r <= SU_H1;
        SU_H1: if (div_done) begin
          h_r  <= q13;
          st_r <= SU_I0;
        end
        SU_I0: st_r <= SU_I1;
        SU_I1: if (div_done && !div_busy) begin
          inv_r <= div_q[INV_W-1:0];
          st_r  <= SU_FIN;
        end
        SU_FIN: begin
          offx_r <= dx_diff[DST_DIM_W-1:1];
          offy_r <= dy_diff[DST_DIM_W-1:1];
          bgpm_r <= {bg_a, premul(bg_raw_r[23:16], bg_a), premul(bg_raw_r[15:8], bg_a),
                     premul(bg_raw_r[7:0], bg_a)};
          st_r   <= SU_IDLE;
        end
        default: st_r <= SU_IDLE;
      endcase
    end
  end

  assign cfg_ready = (st_r == SU_IDLE);

  always_comb begin
    su.src_w     = sw_c;
    su.src_h     = sh_c;
    su.dst_w     = dw_c;
    su.dst_h     = dh_c;
    su.inv_scale = inv_r;
    su.scaled_w  = w_r;
    su.scaled_h  = h_r;
    su.off_x     = offx_r;
    su.off_y     = offy_r;
    su.bg_pm     = bgpm_r;
    su.fmt       = fmt_r;
    su.bottom_up = bu_r;
  end

endmodule

// ===== design/bilinear_fit_scaler_unit.sv =====
// Top level of the bilinear fit scaler: load/fetch sequencer and pixel datapath.
// Depends on bfs_pkg, bfs_setup and bfs_ram.

// A load request writes one source pixel (premultiplied, copied or made opaque
// by the format register) into a 256x256 frame store in the cycle it is accepted
// and gives no result. A fetch request is checked against the image; for a pixel
// inside it the source position is computed, the four neighbors are read one
// after another from the single-port frame store, then blended horizontally,
// vertically and composited over the background, while a pixel outside the image
// goes straight to the output with the background color. The next request is taken
// once the result sits in the output register. A configuration write to a defined
// index recomputes the fit geometry with a one-bit-per-cycle divider, during which
// requests stall and the config port is not ready. The frame store is not cleared:
// fetching a pixel never loaded gives undefined data.
module bilinear_fit_scaler_unit import bfs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_rsp_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_CHK  = 4'd1;
  localparam logic [3:0] ST_POS  = 4'd2;
  localparam logic [3:0] ST_R0   = 4'd3;
  localparam logic [3:0] ST_R1   = 4'd4;
  localparam logic [3:0] ST_R2   = 4'd5;
  localparam logic [3:0] ST_R3   = 4'd6;
  localparam logic [3:0] ST_R4   = 4'd7;
  localparam logic [3:0] ST_HOR  = 4'd8;
  localparam logic [3:0] ST_VER  = 4'd9;
  localparam logic [3:0] ST_CMP  = 4'd10;

  localparam int PW = COORD_W + 1 + INV_W;   // position product width
  localparam int HW = 8 + WT_W;              // horizontal blend width
  localparam int VW = HW + WT_W + 1;         // vertical sum width

  typedef struct packed {
    logic [COL_BITS-1:0]  p0;
    logic [COL_BITS-1:0]  p1;
    logic [FRAC_BITS-1:0] wt;
  } pos_t;

  // ((2d+1)*inv - 1.0) / 2, clamped to the last sample
  function automatic pos_t src_pos(input logic [COORD_W-1:0] d,
                                   input logic [INV_W-1:0] inv,
                                   input logic [SRC_DIM_W-1:0] size);
    logic [PW-1:0]        prod, pos, lim;
    logic [SRC_DIM_W-1:0] nx, sm1;
    pos_t                 r;
    prod = PW'({d, 1'b1}) * PW'(inv);
    pos  = (prod - PW'(ONE_Q)) >> 1;
    sm1  = size - 1'b1;
    lim  = PW'(sm1) << FRAC_BITS;
    if (pos > lim) pos = lim;
    r.p0 = pos[FRAC_BITS+COL_BITS-1:FRAC_BITS];
    nx   = {1'b0, r.p0} + 1'b1;
    r.p1 = (nx < size) ? nx[COL_BITS-1:0] : sm1[COL_BITS-1:0];
    r.wt = pos[FRAC_BITS-1:0];
    return r;
  endfunction

  function automatic logic [HW-1:0] blend(input logic [7:0] a, input logic [7:0] b,
                                          input logic [FRAC_BITS-1:0] w);
    logic [WT_W-1:0] iw;
    iw = WT_W'(ONE_Q) - {1'b0, w};
    return HW'(a) * HW'(iw) + HW'(b) * HW'({1'b0, w});
  endfunction

  setup_t su;

  bfs_setup u_setup (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .su        (su)
  );

  logic [3:0]           st_r;
  logic                 acc;
  logic [COL_BITS-1:0]  ld_col_r, lc;
  logic [ROW_BITS-1:0]  ld_row_r, lr, lr_mem;
  logic [SRC_DIM_W-1:0] lc_inc, lr_inc, lr_flip;
  logic [7:0]           pb, pg, pr, pa;

  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_addr;
  logic [PIX_W-1:0]     mem_wdata, mem_rdata;

  logic [COORD_W-1:0]   x_r, y_r, dx_r, dy_r;
  logic                 inside_r, outside;
  logic [DST_DIM_W:0]   x_end, y_end;
  pos_t                 px, py, px_r, py_r;
  logic [PIX_W-1:0]     p_r [0:3];
  logic [HW-1:0]        top_r [0:3];
  logic [HW-1:0]        bot_r [0:3];
  logic [7:0]           s_r [0:3];
  logic                 out_valid_r, out_free;
  out_rsp_t             out_data_r, res;

  assign acc      = in_valid && !in_stall;
  assign in_stall = (st_r != ST_IDLE) || !cfg_ready;
  assign out_free = !out_valid_r || !out_stall;

  // load position: restart on start_of_frame or when beyond the current size
  always_comb begin
    lc = in_data.start_of_frame ? '0 : ld_col_r;
    lr = in_data.start_of_frame ? '0 : ld_row_r;
    if ({1'b0, lc} >= su.src_w) lc = '0;
    if ({1'b0, lr} >= su.src_h) lr = '0;
    lc_inc  = {1'b0, lc} + 1'b1;
    lr_inc  = {1'b0, lr} + 1'b1;
    lr_flip = su.src_h - 1'b1 - {1'b0, lr};
    lr_mem  = su.bottom_up ? lr_flip[ROW_BITS-1:0] : lr;
  end

  always_comb begin
    pb = in_data.in_blue;
    pg = in_data.in_green;
    pr = in_data.in_red;
    pa = in_data.in_alpha;
    case (su.fmt)
      FMT_STRAIGHT: begin
        pb = premul(in_data.in_blue, in_data.in_alpha);
        pg = premul(in_data.in_green, in_data.in_alpha);
        pr = premul(in_data.in_red, in_data.in_alpha);
      end
      FMT_OPAQUE: pa = 8'd255;
      default: ;
    endcase
  end

  // store port: load writes in idle, fetch reads the 2x2 neighborhood
  always_comb begin
    mem_we    = acc && (in_data.operation == OP_LOAD);
    mem_wdata = {pa, pr, pg, pb};
    case (st_r)
      ST_R0:   mem_addr = {py_r.p0, px_r.p0};
      ST_R1:   mem_addr = {py_r.p0, px_r.p1};
      ST_R2:   mem_addr = {py_r.p1, px_r.p0};
      ST_R3:   mem_addr = {py_r.p1, px_r.p1};
      default: mem_addr = {lr_mem, lc};
    endcase
  end

  bfs_ram #(.AW(ADDR_BITS), .DW(PIX_W)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // image area test
  always_comb begin
    x_end   = {2'b0, su.off_x} + {1'b0, su.scaled_w};
    y_end   = {2'b0, su.off_y} + {1'b0, su.scaled_h};
    outside = ({1'b0, x_r} >= su.dst_w) || ({1'b0, y_r} >= su.dst_h) ||
              (x_r < su.off_x) || ({2'b0, x_r} >= x_end) ||
              (y_r < su.off_y) || ({2'b0, y_r} >= y_end);
    px = src_pos(dx_r, su.inv_scale, su.src_w);
    py = src_pos(dy_r, su.inv_scale, su.src_h);
  end

  // composite over premultiplied background, wrapping to 8 bits;
  // channel 0 is blue, which sits highest in the result struct
  always_comb begin
    logic [7:0]  inv_a, bgc;
    logic [16:0] prod;
    logic [7:0]  sum;
    res = '0;
    inv_a = 8'd255 - s_r[3];
    for (int ch = 0; ch < 4; ch++) begin
      bgc  = su.bg_pm[8*ch +: 8];
      prod = 17'(bgc) * 17'(inv_a) + 17'd127;
      sum  = s_r[ch] + div255(prod);
      res[1 + 8*(3-ch) +: 8] = inside_r ? sum : bgc;
    end
    res.inside_image = inside_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      ld_col_r    <= '0;
      ld_row_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && st_r != ST_CMP) out_valid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (acc) begin
          if (in_data.operation == OP_LOAD) begin
            if (lc_inc >= su.src_w) begin
              ld_col_r <= '0;
              ld_row_r <= (lr_inc >= su.src_h) ? '0 : lr_inc[ROW_BITS-1:0];
            end else begin
              ld_col_r <= lc_inc[COL_BITS-1:0];
              ld_row_r <= lr;
            end
          end else begin
            st_r <= ST_CHK;
          end
        end
        ST_CHK:  st_r <= outside ? ST_CMP : ST_POS;
        ST_POS:  st_r <= ST_R0;
        ST_R0:   st_r <= ST_R1;
        ST_R1:   st_r <= ST_R2;
        ST_R2:   st_r <= ST_R3;
        ST_R3:   st_r <= ST_R4;
        ST_R4:   st_r <= ST_HOR;
        ST_HOR:  st_r <= ST_VER;
        ST_VER:  st_r <= ST_CMP;
        ST_CMP: if (out_free) begin
          out_valid_r <= 1'b1;
          st_r        <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // fetch datapath
  always_ff @(posedge clk) begin
    logic [VW-1:0] v;
    if (acc) begin
      x_r <= in_data.dest_x;
      y_r <= in_data.dest_y;
    end
    if (st_r == ST_CHK) begin
      inside_r <= !outside;
      dx_r     <= x_r - su.off_x;
      dy_r     <= y_r - su.off_y;
    end
    if (st_r == ST_POS) begin
      px_r <= px;
      py_r <= py;
    end
    if (st_r == ST_R1) p_r[0] <= mem_rdata;
    if (st_r == ST_R2) p_r[1] <= mem_rdata;
    if (st_r == ST_R3) p_r[2] <= mem_rdata;
    if (st_r == ST_R4) p_r[3] <= mem_rdata;
    if (st_r == ST_HOR) begin
      for (int ch = 0; ch < 4; ch++) begin
        top_r[ch] <= blend(p_r[0][8*ch +: 8], p_r[1][8*ch +: 8], px_r.wt);
        bot_r[ch] <= blend(p_r[2][8*ch +: 8], p_r[3][8*ch +: 8], px_r.wt);
      end
    end
    if (st_r == ST_VER) begin
      for (int ch = 0; ch < 4; ch++) begin
        v = VW'(top_r[ch]) * VW'(WT_W'(ONE_Q) - {1'b0, py_r.wt})
          + VW'(bot_r[ch]) * VW'({1'b0, py_r.wt})
          + (VW'(1) << (2*FRAC_BITS - 1));
        s_r[ch] <= (v[VW-1:2*FRAC_BITS] > 255) ? 8'd255 : v[2*FRAC_BITS +: 8];
      end
    end
    if (st_r == ST_CMP && out_free) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
